>>> design/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and constants of the linear-probing hash table: operation and
// status codes, field widths and stream packing widths.
// ----------------------------------------------------------------------------
package lpht_pkg;

   // field widths
   localparam int KEY_W      = 16;
   localparam int VAL_W      = 16;
   localparam int STATUS_W   = 2;
   localparam int PROBE_W    = 8;
   localparam int COLL_W     = 15;
   localparam int INS_W      = 8;

   // stream word widths, padded to whole bytes
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 48;

   // saturation limits
   localparam logic [COLL_W-1:0] COLL_MAX = 15'h7fff;
   localparam logic [INS_W-1:0]  INS_MAX  = 8'hff;

   // operation codes
   typedef enum logic {
      FUNC_INSERT = 1'b0,
      FUNC_SEARCH = 1'b1
   } func_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_INSERTED  = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_FOUND     = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

endpackage

>>> design/lpht_ram.sv
// ----------------------------------------------------------------------------
// lpht_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module lpht_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing hash table with linear probing: insert into the first empty
// slot from the home slot, search for the first slot holding the key.
// ----------------------------------------------------------------------------
// Sequence: an accepted request word runs through the home slot reduction (ST_MUL,
//   ST_MOD, ST_FOLD) with one shared multiplier, then one slot is checked per
//   cycle through the registered slot read port (ST_START, ST_PROBE), and ST_SEND
//   registers the response once the output register is free.
// Operations do not overlap: req_tready is low while one runs.
// Reset: synchronous; the counters clear at once and a clearing pass
//   empties the slot-used memory before the first request.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
   parameter int TABLE_SIZE = 128
) (
   input  logic                             clock,
   input  logic                             reset,
   // request: tdata = key[15:0], entry_value[31:16]; tuser = func
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [lpht_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                             req_tuser,
   // response: tdata = found_value[15:0], probe_count[23:16],
   //   collision_total[38:24], insert_total[46:39]; tuser = status
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [lpht_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic [lpht_pkg::STATUS_W-1:0]    rsp_tuser
);

   import lpht_pkg::*;

   localparam int IDX_W    = $clog2(TABLE_SIZE);
   localparam int CNT_W    = $clog2(TABLE_SIZE + 1);
   localparam logic [KEY_W-1:0]  SIZE_K    = KEY_W'(TABLE_SIZE);
   localparam logic [KEY_W-1:0]  RECIP     = KEY_W'((1 << KEY_W) / TABLE_SIZE);
   localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(TABLE_SIZE - 1);
   localparam logic [CNT_W-1:0]  LAST_CNT  = CNT_W'(TABLE_SIZE - 1);
   localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(TABLE_SIZE);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL,
      ST_MOD,
      ST_FOLD,
      ST_START,
      ST_PROBE,
      ST_SEND
   } state_type;

   state_type             state_ff;
   logic [IDX_W-1:0]      clr_ff;
   func_type              func_ff;
   logic [KEY_W-1:0]      key_ff;
   logic [VAL_W-1:0]      val_ff;
   logic [KEY_W-1:0]      rem_ff;
   logic [2*KEY_W-1:0]    prod_ff;
   logic [IDX_W-1:0]      pos_ff;
   logic [IDX_W-1:0]      addr_ff;
   logic [CNT_W-1:0]      count_ff;
   logic [COLL_W-1:0]     coll_ff;
   logic [INS_W-1:0]      ins_ff;
   status_type            res_status_ff;
   logic [VAL_W-1:0]      res_found_ff;
   logic [CNT_W-1:0]      res_count_ff;
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [STATUS_W-1:0]   rsp_user_ff;

   logic [KEY_W-1:0]      mul_a;
   logic [KEY_W-1:0]      mul_b;
   logic [2*KEY_W-1:0]    mul_out;
   logic [KEY_W-1:0]      rem_fold;
   logic                  probe_done;
   logic                  insert_commit;
   status_type            probe_status;
   logic [CNT_W-1:0]      probe_cnt;
   logic [COLL_W:0]       coll_sum;
   logic [COLL_W-1:0]     coll_in;
   logic [15:0]           cnt_wide;
   logic [PROBE_W-1:0]    probe_sat;
   logic                  out_free;

   logic                  used_wr_en;
   logic [IDX_W-1:0]      used_wr_addr;
   logic [0:0]            used_wr_data;
   logic [IDX_W-1:0]      rd_addr;
   logic [0:0]            used_rd;
   logic [KEY_W+VAL_W-1:0] kv_rd;

   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] p);
      next_slot = (p == LAST_IDX) ? '0 : p + IDX_W'(1);
   endfunction

   // shared multiplier: key times reciprocal, then quotient times table size
   always_comb begin
      mul_a = key_ff;
      mul_b = RECIP;
      if (state_ff == ST_MOD) begin
         mul_a = prod_ff[2*KEY_W-1:KEY_W];
         mul_b = SIZE_K;
      end
   end

   assign mul_out  = mul_a * mul_b;

   // quotient estimate is at most one low, so one subtract finishes the remainder
   assign rem_fold = (rem_ff >= SIZE_K) ? rem_ff - SIZE_K : rem_ff;

   // slot check: empty, key match, last step or move on
   always_comb begin
      probe_done    = 1'b0;
      insert_commit = 1'b0;
      probe_status  = STATUS_NOT_FOUND;
      probe_cnt     = count_ff;
      if (state_ff == ST_PROBE) begin
         if (!used_rd[0]) begin
            probe_done = 1'b1;
            if (func_ff == FUNC_INSERT) begin
               insert_commit = 1'b1;
               probe_status  = STATUS_INSERTED;
            end
         end else if (func_ff == FUNC_SEARCH && kv_rd[KEY_W-1:0] == key_ff) begin
            probe_done   = 1'b1;
            probe_status = STATUS_FOUND;
         end else if (count_ff == LAST_CNT) begin
            probe_done   = 1'b1;
            probe_cnt    = FULL_CNT;
            probe_status = (func_ff == FUNC_INSERT) ? STATUS_FULL : STATUS_NOT_FOUND;
         end
      end
   end

   // saturating collision total and probe count
   assign coll_sum  = (COLL_W + 1)'(coll_ff) + (COLL_W + 1)'(count_ff);
   assign coll_in   = coll_sum[COLL_W] ? COLL_MAX : coll_sum[COLL_W-1:0];
   assign cnt_wide  = 16'(res_count_ff);
   assign probe_sat = (cnt_wide > 16'd255) ? 8'hff : cnt_wide[PROBE_W-1:0];
   assign out_free  = !rsp_valid_ff || rsp_tready;

   // memory ports
   assign used_wr_en   = (state_ff == ST_CLEAR) || insert_commit;
   assign used_wr_addr = (state_ff == ST_CLEAR) ? clr_ff : pos_ff;
   assign used_wr_data = (state_ff == ST_CLEAR) ? 1'b0 : 1'b1;
   assign rd_addr      = (state_ff == ST_START) ? pos_ff : addr_ff;

   lpht_ram #(.WIDTH(1), .DEPTH(TABLE_SIZE)) u_used_ram (
      .clock   (clock),
      .wr_en   (used_wr_en),
      .wr_addr (used_wr_addr),
      .wr_data (used_wr_data),
      .rd_addr (rd_addr),
      .rd_data (used_rd)
   );

   lpht_ram #(.WIDTH(KEY_W + VAL_W), .DEPTH(TABLE_SIZE)) u_kv_ram (
      .clock   (clock),
      .wr_en   (insert_commit),
      .wr_addr (pos_ff),
      .wr_data ({val_ff, key_ff}),
      .rd_addr (rd_addr),
      .rd_data (kv_rd)
   );

   // sequencer, counters and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         coll_ff      <= '0;
         ins_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && state_ff != ST_SEND) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= next_slot(clr_ff);
               if (clr_ff == LAST_IDX) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_tvalid) begin
                  func_ff  <= func_type'(req_tuser);
                  key_ff   <= req_tdata[KEY_W-1:0];
                  val_ff   <= req_tdata[KEY_W+VAL_W-1:KEY_W];
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               prod_ff  <= mul_out;
               state_ff <= ST_MOD;
            end
            ST_MOD: begin
               rem_ff   <= key_ff - mul_out[KEY_W-1:0];
               state_ff <= ST_FOLD;
            end
            ST_FOLD: begin
               pos_ff   <= rem_fold[IDX_W-1:0];
               state_ff <= ST_START;
            end
            ST_START: begin
               addr_ff  <= next_slot(pos_ff);
               count_ff <= '0;
               state_ff <= ST_PROBE;
            end
            ST_PROBE: begin
               if (probe_done) begin
                  res_status_ff <= probe_status;
                  res_found_ff  <= (probe_status == STATUS_FOUND) ?
                                   kv_rd[KEY_W+VAL_W-1:KEY_W] : '0;
                  res_count_ff  <= probe_cnt;
                  if (insert_commit) begin
                     coll_ff <= coll_in;
                     if (ins_ff != INS_MAX) begin
                        ins_ff <= ins_ff + INS_W'(1);
                     end
                  end
                  state_ff <= ST_SEND;
               end else begin
                  pos_ff   <= addr_ff;
                  addr_ff  <= next_slot(addr_ff);
                  count_ff <= count_ff + CNT_W'(1);
               end
            end
            ST_SEND: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_user_ff  <= res_status_ff;
                  rsp_data_ff  <= {1'b0, ins_ff, coll_ff, probe_sat, res_found_ff};
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

>>> design/lpht_checker.sv
// ----------------------------------------------------------------------------
// lpht_checker
// Port-level checks of the hash table: response hold under back-pressure,
// busy after a request, and found_value zero on every non-found status.
// ----------------------------------------------------------------------------
module lpht_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [lpht_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic [lpht_pkg::STATUS_W-1:0]    rsp_tuser
);

   import lpht_pkg::*;

   // stalled response word stays valid
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response word dropped while stalled");

   // stalled response word holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response word changed while stalled");

   // an accepted request keeps the block busy
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while previous one in progress");

   // found_value is zero unless the key was found
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != STATUS_FOUND) |-> (rsp_tdata[VAL_W-1:0] == '0))
      else $error("found_value not zero on a non-found status");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (.*);
